FILE: rtl/ssba_pkg.sv
// ----------------------------------------------------------------------------
// ssba_pkg
// Shared constants and types for the swap slot bitmap allocator.
// ----------------------------------------------------------------------------
package ssba_pkg;

    localparam int MAX_SLOTS        = 1024;
    localparam int SECTORS_PER_SLOT = 8;

    // free map kept as words of the map memory
    localparam int WORD_W  = 32;
    localparam int N_WORDS = MAX_SLOTS / WORD_W;
    localparam int WORD_AW = $clog2(N_WORDS);
    localparam int BIT_AW  = $clog2(WORD_W);

    localparam int SLOT_W   = 10;
    localparam int SECTOR_W = 13;
    localparam int COUNT_W  = 11;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    typedef logic [WORD_W-1:0]   t_word;
    typedef logic [WORD_AW-1:0]  t_word_addr;
    typedef logic [BIT_AW-1:0]   t_bit_addr;
    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [SECTOR_W-1:0] t_sector;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_cmd CMD_ALLOC   = 2'd0;
    localparam t_cmd CMD_SWAPIN  = 2'd1;
    localparam t_cmd CMD_RELEASE = 2'd2;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_FULL     = 2'd1;
    localparam t_status ST_NOT_USED = 2'd2;
    localparam t_status ST_RANGE    = 2'd3;

    // write request to the map memory
    typedef struct packed {
        logic       en;
        t_word_addr addr;
        t_word      data;
    } t_map_wr;

endpackage

FILE: rtl/ssba_map.sv
// ----------------------------------------------------------------------------
// ssba_map
// Free map memory: one word read and one word write per cycle, registered
// read data. Rows never written read as all free.
// ----------------------------------------------------------------------------
module ssba_map (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ssba_pkg::t_word_addr i_rd_addr,
    output ssba_pkg::t_word      o_rd_data,
    input  ssba_pkg::t_map_wr    i_wr
);

    ssba_pkg::t_word                   r_mem [ssba_pkg::N_WORDS];
    logic [ssba_pkg::N_WORDS-1:0]      r_row_vld;
    ssba_pkg::t_word                   r_rd_data;
    logic                              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // row valid bits stand in for the all-free reset image
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_row_vld[i_wr.addr] <= 1'b1;
            end
            r_rd_vld <= r_row_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '1;

endmodule

FILE: rtl/swap_slot_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// swap_slot_bitmap_allocator_core
// First-fit swap slot allocator over a bitmap free map.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries a command and a slot index.
// Allocate takes the lowest free slot below the active count; swap-in and
// release free an in-use slot. Each command except the unused code gives one
// transaction on the output channel (o_out_valid / i_out_stall) with the slot,
// its first sector and a status.
// The map lives in a 32 x 32-bit memory. Allocate scans one word per cycle
// through the find-first unit from word 0, stopping at the first free slot or
// at the word holding the last active slot. Swap-in and release read the
// slot's word, check that the slot is in use and mark it free. Out-of-range
// commands and allocate with a zero count go straight to emit. One command at a time: the
// input is stalled from acceptance until the result is loaded into the output
// register. A stalled output holds its payload; the block waits in its emit
// step until the register is free.
// The slot count register is written through the cfg channel (always ready)
// and must only change while the block is idle.
// Reset (synchronous, active low) marks every slot free with no clearing pass
// and sets the count to 1024.
// ----------------------------------------------------------------------------
module swap_slot_bitmap_allocator_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // command channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  ssba_pkg::t_cmd           i_cmd,
    input  ssba_pkg::t_slot          i_slot_index,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output ssba_pkg::t_slot          o_slot_out,
    output ssba_pkg::t_sector        o_base_sector,
    output ssba_pkg::t_status        o_status,
    // configuration
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  ssba_pkg::t_count         i_cfg_slots_in_use
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RCHK,
        S_EMIT
    } t_state;

    t_state                r_state, n_state;
    ssba_pkg::t_count      r_slots;
    ssba_pkg::t_slot       r_idx, n_idx;
    ssba_pkg::t_word_addr  r_word, n_word;
    ssba_pkg::t_slot       r_res_slot, n_res_slot;
    ssba_pkg::t_status     r_res_status, n_res_status;
    logic                  r_out_valid, n_out_valid;
    ssba_pkg::t_slot       r_out_slot, n_out_slot;
    ssba_pkg::t_sector     r_out_sector, n_out_sector;
    ssba_pkg::t_status     r_out_status, n_out_status;

    ssba_pkg::t_count      w_cnt;
    ssba_pkg::t_count      w_cnt_m1;
    ssba_pkg::t_word_addr  w_last_word;
    ssba_pkg::t_bit_addr   w_last_bits;
    ssba_pkg::t_word       w_rd_data;
    ssba_pkg::t_word       w_mask;
    ssba_pkg::t_word       w_masked;
    ssba_pkg::t_bit_addr   w_pos;
    ssba_pkg::t_word_addr  w_rd_addr;
    ssba_pkg::t_map_wr     w_wr;
    logic                  w_in_acc;
    logic                  w_out_free;

    // lowest set bit of a word
    function automatic ssba_pkg::t_bit_addr find_first(input ssba_pkg::t_word w);
        ssba_pkg::t_bit_addr p;
        p = '0;
        for (int b = ssba_pkg::WORD_W - 1; b >= 0; b--) begin
            if (w[b]) begin
                p = ssba_pkg::t_bit_addr'(b);
            end
        end
        return p;
    endfunction

    ssba_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr      (w_wr)
    );

    // active count limited to the map size
    assign w_cnt = (r_slots > ssba_pkg::t_count'(ssba_pkg::MAX_SLOTS))
                   ? ssba_pkg::t_count'(ssba_pkg::MAX_SLOTS) : r_slots;
    assign w_cnt_m1    = w_cnt - ssba_pkg::t_count'(1);
    assign w_last_word = w_cnt_m1[ssba_pkg::SLOT_W-1:ssba_pkg::BIT_AW];
    assign w_last_bits = w_cnt_m1[ssba_pkg::BIT_AW-1:0];

    assign w_mask   = (r_word == w_last_word)
                      ? (ssba_pkg::t_word'('1) >> (ssba_pkg::t_bit_addr'(ssba_pkg::WORD_W - 1)
                                                    - w_last_bits))
                      : '1;
    assign w_masked = w_rd_data & w_mask;
    assign w_pos    = find_first(w_masked);

    assign w_in_acc    = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_word       = r_word;
        n_res_slot   = r_res_slot;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_slot   = r_out_slot;
        n_out_sector = r_out_sector;
        n_out_status = r_out_status;
        w_rd_addr    = r_idx[ssba_pkg::SLOT_W-1:ssba_pkg::BIT_AW];
        w_wr.en      = 1'b0;
        w_wr.addr    = r_word;
        w_wr.data    = w_rd_data;

        case (r_state)
            S_IDLE: begin
                w_rd_addr = (i_cmd == ssba_pkg::CMD_ALLOC)
                            ? '0 : i_slot_index[ssba_pkg::SLOT_W-1:ssba_pkg::BIT_AW];
                if (w_in_acc) begin
                    n_idx  = i_slot_index;
                    n_word = '0;
                    if (i_cmd == ssba_pkg::CMD_ALLOC) begin
                        if (w_cnt == '0) begin
                            n_res_slot   = '0;
                            n_res_status = ssba_pkg::ST_FULL;
                            n_state      = S_EMIT;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else if (i_cmd == ssba_pkg::CMD_SWAPIN ||
                                 i_cmd == ssba_pkg::CMD_RELEASE) begin
                        if ({1'b0, i_slot_index} >= w_cnt) begin
                            n_res_slot   = i_slot_index;
                            n_res_status = ssba_pkg::ST_RANGE;
                            n_state      = S_EMIT;
                        end else begin
                            n_state = S_RCHK;
                        end
                    end
                end
            end
            S_SCAN: begin
                w_rd_addr = r_word + ssba_pkg::t_word_addr'(1);
                if (|w_masked) begin
                    w_wr.en      = 1'b1;
                    w_wr.addr    = r_word;
                    w_wr.data    = w_rd_data & ~(ssba_pkg::t_word'(1) << w_pos);
                    n_res_slot   = {r_word, w_pos};
                    n_res_status = ssba_pkg::ST_OK;
                    n_state      = S_EMIT;
                end else if (r_word == w_last_word) begin
                    n_res_slot   = '0;
                    n_res_status = ssba_pkg::ST_FULL;
                    n_state      = S_EMIT;
                end else begin
                    n_word = r_word + ssba_pkg::t_word_addr'(1);
                end
            end
            S_RCHK: begin
                n_res_slot = r_idx;
                if (w_rd_data[r_idx[ssba_pkg::BIT_AW-1:0]]) begin
                    n_res_status = ssba_pkg::ST_NOT_USED;
                end else begin
                    w_wr.en      = 1'b1;
                    w_wr.addr    = r_idx[ssba_pkg::SLOT_W-1:ssba_pkg::BIT_AW];
                    w_wr.data    = w_rd_data
                                   | (ssba_pkg::t_word'(1) << r_idx[ssba_pkg::BIT_AW-1:0]);
                    n_res_status = ssba_pkg::ST_OK;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_slot   = r_res_slot;
                    n_out_status = r_res_status;
                    n_out_sector = (r_res_status == ssba_pkg::ST_OK)
                                   ? ssba_pkg::t_sector'(
                                         ssba_pkg::t_sector'(r_res_slot)
                                         * ssba_pkg::t_sector'(ssba_pkg::SECTORS_PER_SLOT))
                                   : '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_slots     <= ssba_pkg::t_count'(ssba_pkg::MAX_SLOTS);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_slots <= i_cfg_slots_in_use;
            end
        end
        r_idx        <= n_idx;
        r_word       <= n_word;
        r_res_slot   <= n_res_slot;
        r_res_status <= n_res_status;
        r_out_slot   <= n_out_slot;
        r_out_sector <= n_out_sector;
        r_out_status <= n_out_status;
    end

    assign o_out_valid   = r_out_valid;
    assign o_slot_out    = r_out_slot;
    assign o_base_sector = r_out_sector;
    assign o_status      = r_out_status;

    // successful result carries the slot's first sector
    a_ok_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ssba_pkg::ST_OK) |->
        (o_base_sector == ssba_pkg::t_sector'(ssba_pkg::t_sector'(o_slot_out)
                                              * ssba_pkg::t_sector'(ssba_pkg::SECTORS_PER_SLOT))))
        else $error("ok result with wrong base sector");

    // failed results report no sector
    a_fail_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ssba_pkg::ST_OK) |-> (o_base_sector == '0))
        else $error("failed result with nonzero base sector");

    // a loaded ok result always names a slot below the active count
    a_ok_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_free && r_res_status == ssba_pkg::ST_OK) |->
        ({1'b0, r_res_slot} < w_cnt))
        else $error("ok result outside the active slot count");

    // the map is written only from the scan or check steps
    a_wr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |=> (r_state == S_EMIT))
        else $error("map write not followed by emit");

endmodule
